### design/h264db_pkg.sv
`default_nettype none

package h264db_pkg;

    // Sample and field widths.
    localparam int SAMPLE_BITS = 8;
    localparam int THR_BITS    = 8;
    localparam int TC0_BITS    = 5;
    localparam int MODE_BITS   = 2;

    // Signed working width for the filter arithmetic. It holds
    // 4*(q0-p0)+(p1-q1)+4 and the eight-weight tap sums.
    localparam int CALC_BITS = 12;

    // Packed payload widths, padded to whole bytes.
    localparam int IN_DATA_RAW  = 8 * SAMPLE_BITS + 2 * THR_BITS + TC0_BITS;
    localparam int IN_DATA_BITS = ((IN_DATA_RAW + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 6 * SAMPLE_BITS;

    // Filter modes.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_LUMA_NORMAL   = 2'd0,
        MODE_LUMA_STRONG   = 2'd1,
        MODE_CHROMA_NORMAL = 2'd2,
        MODE_CHROMA_STRONG = 2'd3
    } filter_mode_t;

    typedef logic [SAMPLE_BITS-1:0]      sample_t;
    typedef logic signed [CALC_BITS-1:0] calc_t;

    // One registered edge line.
    typedef struct packed {
        sample_t               p3;
        sample_t               p2;
        sample_t               p1;
        sample_t               p0;
        sample_t               q0;
        sample_t               q1;
        sample_t               q2;
        sample_t               q3;
        logic [THR_BITS-1:0]   alpha;
        logic [THR_BITS-1:0]   beta;
        logic [TC0_BITS-1:0]   tc0;
        filter_mode_t          mode;
    } edge_line_t;

    // Absolute difference of two samples.
    function automatic sample_t abs_diff(input sample_t a, input sample_t b);
        sample_t d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    // Widen a sample into the signed working width.
    function automatic calc_t widen(input sample_t s);
        calc_t w;
        w = calc_t'({{(CALC_BITS - SAMPLE_BITS){1'b0}}, s});
        return w;
    endfunction

    // Clip x into the range lo..hi.
    function automatic calc_t clip3(input calc_t lo, input calc_t hi, input calc_t x);
        calc_t r;
        if (x < lo)
        begin
            r = lo;
        end
        else if (x > hi)
        begin
            r = hi;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

    // Clip a signed value into the sample range.
    function automatic sample_t clip_pixel(input calc_t x);
        sample_t r;
        if (x < 0)
        begin
            r = '0;
        end
        else if (x > widen({SAMPLE_BITS{1'b1}}))
        begin
            r = {SAMPLE_BITS{1'b1}};
        end
        else
        begin
            r = x[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/h264_deblock_edge_filter_core.sv
`default_nettype none

// Channel   Dir  Word                                          Side info
// s_axis    in   tdata: p3,p2,p1,p0,q0,q1,q2,q3,alpha,beta,tc0  tuser: filter_mode
// m_axis    out  tdata: p2,p1,p0,q0,q1,q2 (filtered)             tuser: edge_active
//
// One edge line per clock is sustained while the output is not stalled. Each word
// passes an input register, one stage of gate, delta and tap logic, and a result
// register. A stalled output holds the result register; the input register still
// takes a word while it is empty.
// rst_n clears the valid flags only; payload registers are not reset.

module h264_deblock_edge_filter_core
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // p3, p2, p1, p0, q0, q1, q2, q3, alpha_thr, beta_thr, clip_tc0, zero pad
    input  wire logic [h264db_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // filter_mode
    input  wire logic [h264db_pkg::MODE_BITS-1:0]     s_axis_tuser,

    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // out_p2, out_p1, out_p0, out_q0, out_q1, out_q2
    output logic [h264db_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
    // edge_active
    output logic [0:0]                                m_axis_tuser
);

    localparam int SB = h264db_pkg::SAMPLE_BITS;
    localparam int TB = h264db_pkg::THR_BITS;

    // Pipeline registers.
    logic                                   in_valid_reg;
    h264db_pkg::edge_line_t                 in_line_reg;
    logic                                   out_valid_reg;
    logic [h264db_pkg::OUT_DATA_BITS-1:0]   out_data_reg;
    logic                                   out_active_reg;

    logic                                   advance;
    h264db_pkg::edge_line_t                 line_next;

    // Filter stage signals.
    h264db_pkg::calc_t   p3s, p2s, p1s, p0s, q0s, q1s, q2s, q3s;
    h264db_pkg::calc_t   tc_s, tc0_s, delta_raw, delta;
    h264db_pkg::calc_t   avg_s, p1_tmp, q1_tmp, p1_adj, q1_adj;
    h264db_pkg::calc_t   p0_3tap, p1_3tap, p2_3tap, q0_3tap, q1_3tap, q2_3tap;
    h264db_pkg::calc_t   p0_1tap, q0_1tap;
    logic [5:0]          tc_sum;
    logic [TB:0]         flat_limit;
    logic                gate_on, ap, aq, flat_edge;
    h264db_pkg::sample_t np2, np1, np0, nq0, nq1, nq2;

    // Handshake: the output advances when empty or taken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    // Unpack the input word.
    always_comb
    begin
        line_next.p3    = s_axis_tdata[0*SB +: SB];
        line_next.p2    = s_axis_tdata[1*SB +: SB];
        line_next.p1    = s_axis_tdata[2*SB +: SB];
        line_next.p0    = s_axis_tdata[3*SB +: SB];
        line_next.q0    = s_axis_tdata[4*SB +: SB];
        line_next.q1    = s_axis_tdata[5*SB +: SB];
        line_next.q2    = s_axis_tdata[6*SB +: SB];
        line_next.q3    = s_axis_tdata[7*SB +: SB];
        line_next.alpha = s_axis_tdata[8*SB +: TB];
        line_next.beta  = s_axis_tdata[8*SB + TB +: TB];
        line_next.tc0   = s_axis_tdata[8*SB + 2*TB +: h264db_pkg::TC0_BITS];
        line_next.mode  = h264db_pkg::filter_mode_t'(s_axis_tuser);
    end

    // Activity gate and side activity.
    always_comb
    begin
        gate_on = (h264db_pkg::abs_diff(in_line_reg.p0, in_line_reg.q0) < in_line_reg.alpha)
               && (h264db_pkg::abs_diff(in_line_reg.p1, in_line_reg.p0) < in_line_reg.beta)
               && (h264db_pkg::abs_diff(in_line_reg.q1, in_line_reg.q0) < in_line_reg.beta);
        ap = h264db_pkg::abs_diff(in_line_reg.p2, in_line_reg.p0) < in_line_reg.beta;
        aq = h264db_pkg::abs_diff(in_line_reg.q2, in_line_reg.q0) < in_line_reg.beta;
        flat_limit = {2'b00, in_line_reg.alpha[TB-1:2]} + (TB+1)'(2);
        flat_edge = {1'b0, h264db_pkg::abs_diff(in_line_reg.p0, in_line_reg.q0)} < flat_limit;
    end

    // Normal filter: clipped delta and the p1/q1 corrections.
    always_comb
    begin
        p3s = h264db_pkg::widen(in_line_reg.p3);
        p2s = h264db_pkg::widen(in_line_reg.p2);
        p1s = h264db_pkg::widen(in_line_reg.p1);
        p0s = h264db_pkg::widen(in_line_reg.p0);
        q0s = h264db_pkg::widen(in_line_reg.q0);
        q1s = h264db_pkg::widen(in_line_reg.q1);
        q2s = h264db_pkg::widen(in_line_reg.q2);
        q3s = h264db_pkg::widen(in_line_reg.q3);

        if (in_line_reg.mode == h264db_pkg::MODE_LUMA_NORMAL)
        begin
            tc_sum = {1'b0, in_line_reg.tc0} + {5'b0, ap} + {5'b0, aq};
        end
        else
        begin
            tc_sum = {1'b0, in_line_reg.tc0} + 6'd1;
        end
        tc_s  = h264db_pkg::calc_t'({6'b0, tc_sum});
        tc0_s = h264db_pkg::calc_t'({7'b0, in_line_reg.tc0});

        delta_raw = ((q0s - p0s) <<< 2) + (p1s - q1s) + h264db_pkg::calc_t'(4);
        delta     = h264db_pkg::clip3(-tc_s, tc_s, delta_raw >>> 3);

        avg_s  = (p0s + q0s + h264db_pkg::calc_t'(1)) >>> 1;
        p1_tmp = (p2s + avg_s - (p1s <<< 1)) >>> 1;
        q1_tmp = (q2s + avg_s - (q1s <<< 1)) >>> 1;
        p1_adj = h264db_pkg::clip3(-tc0_s, tc0_s, p1_tmp);
        q1_adj = h264db_pkg::clip3(-tc0_s, tc0_s, q1_tmp);
    end

    // Strong filter tap sums; all are non-negative.
    always_comb
    begin
        p0_3tap = p2s + (p1s <<< 1) + (p0s <<< 1) + (q0s <<< 1) + q1s
                + h264db_pkg::calc_t'(4);
        p1_3tap = p2s + p1s + p0s + q0s + h264db_pkg::calc_t'(2);
        p2_3tap = (p3s <<< 1) + p2s + (p2s <<< 1) + p1s + p0s + q0s
                + h264db_pkg::calc_t'(4);
        q0_3tap = q2s + (q1s <<< 1) + (q0s <<< 1) + (p0s <<< 1) + p1s
                + h264db_pkg::calc_t'(4);
        q1_3tap = q2s + q1s + q0s + p0s + h264db_pkg::calc_t'(2);
        q2_3tap = (q3s <<< 1) + q2s + (q2s <<< 1) + q1s + q0s + p0s
                + h264db_pkg::calc_t'(4);
        p0_1tap = (p1s <<< 1) + p0s + q1s + h264db_pkg::calc_t'(2);
        q0_1tap = (q1s <<< 1) + q0s + p1s + h264db_pkg::calc_t'(2);
    end

    // Output sample selection by mode.
    always_comb
    begin
        np2 = in_line_reg.p2;
        np1 = in_line_reg.p1;
        np0 = in_line_reg.p0;
        nq0 = in_line_reg.q0;
        nq1 = in_line_reg.q1;
        nq2 = in_line_reg.q2;
        if (gate_on)
        begin
            case (in_line_reg.mode)
                h264db_pkg::MODE_LUMA_NORMAL:
                begin
                    np0 = h264db_pkg::clip_pixel(p0s + delta);
                    nq0 = h264db_pkg::clip_pixel(q0s - delta);
                    if (ap)
                    begin
                        np1 = h264db_pkg::clip_pixel(p1s + p1_adj);
                    end
                    if (aq)
                    begin
                        nq1 = h264db_pkg::clip_pixel(q1s + q1_adj);
                    end
                end
                h264db_pkg::MODE_LUMA_STRONG:
                begin
                    if (ap && flat_edge)
                    begin
                        np0 = p0_3tap[SB+2:3];
                        np1 = p1_3tap[SB+1:2];
                        np2 = p2_3tap[SB+2:3];
                    end
                    else
                    begin
                        np0 = p0_1tap[SB+1:2];
                    end
                    if (aq && flat_edge)
                    begin
                        nq0 = q0_3tap[SB+2:3];
                        nq1 = q1_3tap[SB+1:2];
                        nq2 = q2_3tap[SB+2:3];
                    end
                    else
                    begin
                        nq0 = q0_1tap[SB+1:2];
                    end
                end
                h264db_pkg::MODE_CHROMA_NORMAL:
                begin
                    np0 = h264db_pkg::clip_pixel(p0s + delta);
                    nq0 = h264db_pkg::clip_pixel(q0s - delta);
                end
                default:
                begin
                    np0 = p0_1tap[SB+1:2];
                    nq0 = q0_1tap[SB+1:2];
                end
            endcase
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_line_reg <= line_next;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg   <= {nq2, nq1, nq0, np0, np1, np2};
            out_active_reg <= gate_on;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_active_reg;

endmodule

`default_nettype wire
